FILE: design/crc8_checked_ascii_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// crc8_checked_ascii_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`ifndef CRC8_CHECKED_ASCII_FRAME_RECEIVER_DEFINES_SVH
`define CRC8_CHECKED_ASCII_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled while reset is active.
`define CRC8CAFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("crc8cafr: assertion failed");

// Next-cycle implication, sampled on aclk and disabled while reset is active.
`define CRC8CAFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("crc8cafr: assertion failed");

`endif

FILE: design/crc8cafr_pkg.sv
// ----------------------------------------------------------------------------
// crc8cafr_pkg
// Types, character codes and CRC-8 helpers for the ASCII frame receiver.
// ----------------------------------------------------------------------------
package crc8cafr_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [7:0] CH_W    = 8'h77;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_Z    = 8'h7A;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_F = 8'h66;

    localparam int unsigned HDR_LEN       = 3;
    localparam logic [1:0]  HDR_LAST_BEAT = 2'd2;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_GOOD     = 2'd1,
        ST_BAD      = 2'd2,
        ST_ABORT    = 2'd3
    } status_t;

    // One result from the parser; hdr expands into the three header beats.
    typedef struct packed {
        logic       emit;
        logic       hdr;
        logic [7:0] frame_byte;
        logic       last;
        status_t    status;
        logic [7:0] crc;
    } res_t;

    // Hex digit decode: {valid, value}.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h = '0;
        if (b inside {[CH_0:CH_9]}) begin
            h.valid = 1'b1;
            h.value = 4'(b - CH_0);
        end else if (b inside {[CH_UA:CH_UF]}) begin
            h.valid = 1'b1;
            h.value = 4'(b - CH_UA + 8'd10);
        end else if (b inside {[CH_LA:CH_LF_F]}) begin
            h.valid = 1'b1;
            h.value = 4'(b - CH_LA + 8'd10);
        end
        return h;
    endfunction

    localparam logic [7:0] HDR_CRC = crc8_update(crc8_update(crc8_update(8'h00, CH_W), CH_R), CH_Z);

endpackage

FILE: design/crc8cafr_in_skid.sv
// ----------------------------------------------------------------------------
// crc8cafr_in_skid
// Input register with a skid entry, so that s_tready comes from a flop.
// ----------------------------------------------------------------------------
module crc8cafr_in_skid (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       byte_valid,
    input  logic       byte_ready,
    output logic [7:0] byte_data
);

    logic       main_valid_reg;
    logic [7:0] main_data_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;
    logic       s_accept;

    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign byte_valid = main_valid_reg;
    assign byte_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (byte_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_ready || !main_valid_reg) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : s_tdata;
        end else if (s_accept) begin
            skid_data_reg <= s_tdata;
        end
    end

endmodule

FILE: design/crc8cafr_parser.sv
// ----------------------------------------------------------------------------
// crc8cafr_parser
// Header search, frame state, running CRC and checksum collection.
// ----------------------------------------------------------------------------
`include "crc8_checked_ascii_frame_receiver_defines.svh"

module crc8cafr_parser #(
    parameter int MAX_FRAME_LEN = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [7:0]           rx_byte,
    output crc8cafr_pkg::res_t   res
);
    import crc8cafr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

    logic [7:0]       win0_reg, win0_next;
    logic [7:0]       win1_reg, win1_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_frame_reg, in_frame_next;
    logic [7:0]       crc_reg, crc_next;
    logic             star_reg, star_next;
    logic             hex_reg, hex_next;
    logic [7:0]       rcv_reg, rcv_next;
    hex_t             hv;

    assign hv = hex_decode(rx_byte);

    always_comb begin
        win0_next     = win0_reg;
        win1_next     = win1_reg;
        cnt_next      = cnt_reg;
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        star_next     = star_reg;
        hex_next      = hex_reg;
        rcv_next      = rcv_reg;
        res           = '0;
        if (take) begin
            if (!in_frame_reg) begin
                if (win0_reg == CH_W && win1_reg == CH_R && rx_byte == CH_Z) begin
                    in_frame_next = 1'b1;
                    cnt_next      = CNT_W'(HDR_LEN);
                    crc_next      = HDR_CRC;
                    star_next     = 1'b0;
                    hex_next      = 1'b0;
                    rcv_next      = 8'h00;
                    win0_next     = 8'h00;
                    win1_next     = 8'h00;
                    res.emit      = 1'b1;
                    res.hdr       = 1'b1;
                end else begin
                    win0_next = win1_reg;
                    win1_next = rx_byte;
                end
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (!star_reg) begin
                    if (rx_byte == CH_STAR) begin
                        star_next = 1'b1;
                        hex_next  = 1'b1;
                        rcv_next  = 8'h00;
                    end else begin
                        crc_next = crc8_update(crc_reg, rx_byte);
                    end
                end else if (hex_reg) begin
                    if (hv.valid) begin
                        rcv_next = {rcv_reg[3:0], hv.value};
                    end else begin
                        hex_next = 1'b0;
                    end
                end
                res.emit       = 1'b1;
                res.frame_byte = rx_byte;
                if (cnt_next >= CNT_W'(MAX_FRAME_LEN) ||
                    rx_byte == CH_CR || rx_byte == CH_LF) begin
                    res.last = 1'b1;
                    res.crc  = crc_next;
                    if (cnt_next >= CNT_W'(MAX_FRAME_LEN)) begin
                        res.status = ST_ABORT;
                    end else if (star_next && rcv_next == crc_next) begin
                        res.status = ST_GOOD;
                    end else begin
                        res.status = ST_BAD;
                    end
                    // Leaving the frame clears everything, header window included.
                    in_frame_next = 1'b0;
                    cnt_next      = '0;
                    crc_next      = 8'h00;
                    star_next     = 1'b0;
                    hex_next      = 1'b0;
                    rcv_next      = 8'h00;
                    win0_next     = 8'h00;
                    win1_next     = 8'h00;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg     <= 8'h00;
            win1_reg     <= 8'h00;
            cnt_reg      <= '0;
            in_frame_reg <= 1'b0;
            crc_reg      <= 8'h00;
            star_reg     <= 1'b0;
            hex_reg      <= 1'b0;
            rcv_reg      <= 8'h00;
        end else begin
            win0_reg     <= win0_next;
            win1_reg     <= win1_next;
            cnt_reg      <= cnt_next;
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
            star_reg     <= star_next;
            hex_reg      <= hex_next;
            rcv_reg      <= rcv_next;
        end
    end

    `CRC8CAFR_ASSERT_NOW(a_idle_clear, !in_frame_reg, cnt_reg == '0 && !star_reg && crc_reg == 8'h00)
    `CRC8CAFR_ASSERT_NOW(a_hex_needs_star, hex_reg, star_reg)
    `CRC8CAFR_ASSERT_NOW(a_cnt_range, in_frame_reg, cnt_reg >= CNT_W'(HDR_LEN) && cnt_reg < CNT_W'(MAX_FRAME_LEN))

endmodule

FILE: design/crc8cafr_out_stage.sv
// ----------------------------------------------------------------------------
// crc8cafr_out_stage
// Result register; plays a header result out as three beats.
// ----------------------------------------------------------------------------
`include "crc8_checked_ascii_frame_receiver_defines.svh"

module crc8cafr_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  crc8cafr_pkg::res_t res,
    output logic               load_ok,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);
    import crc8cafr_pkg::*;

    logic       valid_reg;
    logic [1:0] beat_reg;
    res_t       data_reg;
    logic       final_beat;
    logic [7:0] out_byte;

    assign final_beat = !data_reg.hdr || beat_reg == HDR_LAST_BEAT;
    assign load_ok    = !valid_reg || (m_tready && final_beat);

    always_comb begin
        out_byte = data_reg.frame_byte;
        if (data_reg.hdr) begin
            case (beat_reg)
                2'd0:    out_byte = CH_W;
                2'd1:    out_byte = CH_R;
                default: out_byte = CH_Z;
            endcase
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.crc, out_byte};
    assign m_tlast  = data_reg.last;
    assign m_tuser  = data_reg.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= 2'd0;
        end else if (load_ok) begin
            valid_reg <= res.emit;
            beat_reg  <= 2'd0;
        end else if (m_tready) begin
            beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok) begin
            data_reg <= res;
        end
    end

    `CRC8CAFR_ASSERT_NOW(a_beat_only_hdr, beat_reg != 2'd0, valid_reg && data_reg.hdr)
    `CRC8CAFR_ASSERT_NOW(a_hdr_not_last, valid_reg && data_reg.hdr, !data_reg.last && data_reg.status == ST_CONTINUE)
    `CRC8CAFR_ASSERT_NEXT(a_hdr_step, valid_reg && m_tready && data_reg.hdr && beat_reg != HDR_LAST_BEAT, valid_reg && beat_reg == $past(beat_reg) + 2'd1)

endmodule

FILE: design/crc8_checked_ascii_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_checked_ascii_frame_receiver
// Deframer for "wrz" ASCII sentences with a CRC-8 (poly 0x07) hex checksum.
//
//   Channel | Ports    | Contents
//   --------+----------+----------------------------------------------------
//   input   | s_t*     | tdata[7:0] = rx_byte
//   output  | m_t*     | tdata[7:0] = frame_byte, tdata[15:8] = computed_crc,
//           |          | tlast = last, tuser[1:0] = status
//
// A byte that completes the header yields three output transfers, 'w', 'r'
// and 'z', and the parser takes no new byte until the last one is accepted.
// The path is: input skid register, one pass of parse and CRC logic, result
// register. Throughput is one byte per cycle unless m_tready or a header stalls.
// Reset (aresetn low, synchronous) drops any pending transfers and clears the
// header window and all frame state. Stalls on m_tready back up through the
// result register into the two-entry input stage; s_tready is a flop output.
// ----------------------------------------------------------------------------
module crc8_checked_ascii_frame_receiver #(
    parameter int MAX_FRAME_LEN = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream, one received byte per transfer.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream, one frame byte per transfer.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] frame_byte, [15:8] computed_crc
    output logic        m_tlast,   // last: the byte that ends or aborts a frame
    output logic [1:0]  m_tuser    // [1:0] status
);
    import crc8cafr_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       load_ok;
    logic       take;
    res_t       res;

    // The parser consumes a byte whenever the result register can be loaded
    // in the same cycle; bytes outside a frame, but for the header's last, leave it empty.
    assign take = byte_valid && load_ok;

    crc8cafr_in_skid u_in_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_ready (load_ok),
        .byte_data  (byte_data)
    );

    // Frame state, running CRC and checksum compare in a single pass.
    crc8cafr_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .rx_byte (byte_data),
        .res     (res)
    );

    // Result register; a header result is played out as 'w', 'r', 'z'.
    crc8cafr_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
